// ===== src/ttpc_pkg.sv =====
// Shared types, codes and constants of the tracker pattern cell packer.
package ttpc_pkg;

  localparam int CHANNELS   = 32;
  localparam int CH_W       = 5;
  localparam int CH_IDX_W   = $clog2(CHANNELS);
  localparam int OP_W       = 2;
  localparam int DATA_W     = 56;
  localparam int BYTES_MAX  = 7;
  localparam int CNT_W      = 3;
  localparam int CACHE_W    = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Item kinds carried in tuser
  localparam logic [OP_W-1:0] OP_CELL    = 2'd0;
  localparam logic [OP_W-1:0] OP_END_ROW = 2'd1;
  localparam logic [OP_W-1:0] OP_PATTERN = 2'd2;
  localparam logic [OP_W-1:0] OP_RESET   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_VOL_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_NOTE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_CUT       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_OFF       = 2'd3;

  // Mask byte bits
  localparam logic [7:0] FLAG_NOTE    = 8'h01;
  localparam logic [7:0] FLAG_INSTR   = 8'h02;
  localparam logic [7:0] FLAG_VOLC    = 8'h04;
  localparam logic [7:0] FLAG_EFFC    = 8'h08;
  localparam logic [7:0] MODE_PLAY    = 8'h10;
  localparam logic [7:0] MODE_DEF_VOL = 8'h20;
  localparam logic [7:0] MODE_VOL_CMD = 8'h40;
  localparam logic [7:0] MODE_FX_CMD  = 8'h80;
  localparam logic [7:0] NEW_MASK_BIT = 8'h80;

  localparam logic [7:0] END_ROW_BYTE    = 8'h00;
  localparam logic [7:0] EMPTY_VOL_HIGH  = 8'hFF;
  localparam logic [7:0] EMPTY_VOL_LOW   = 8'h00;
  localparam logic [CACHE_W-1:0] NOTHING_CACHED = 9'h100;

  localparam logic [7:0] RST_EMPTY_NOTE = 8'd250;
  localparam logic [7:0] RST_NOTE_CUT   = 8'd254;
  localparam logic [7:0] RST_NOTE_OFF   = 8'd255;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [CH_W-1:0] channel;
    logic [7:0]      note;
    logic [7:0]      instrument;
    logic [7:0]      volume;
    logic [7:0]      effect;
    logic [7:0]      effect_param;
    logic [8:0]      row_total;
  } item_t;

  typedef struct packed {
    logic       empty_volume_high;
    logic [7:0] empty_note;
    logic [7:0] note_cut_code;
    logic [7:0] note_off_code;
  } cfg_t;

  typedef logic [BYTES_MAX-1:0][7:0] burst_bytes_t;

  typedef struct packed {
    burst_bytes_t     bytes;
    logic [CNT_W-1:0] count;
  } burst_t;

endpackage

// ===== src/ttpc_cell_encoder.sv =====
// Per-channel caches and the encoder that turns one item into its burst of bytes.
module ttpc_cell_encoder (
  input  logic            clk,
  input  logic            rst,
  input  ttpc_pkg::item_t item,
  input  ttpc_pkg::cfg_t  cfg,
  input  logic            fire,
  output ttpc_pkg::burst_t burst
);
  import ttpc_pkg::*;

  logic [CHANNELS-1:0] valid;
  logic [CACHE_W-1:0]  mask_cache  [CHANNELS];
  logic [CACHE_W-1:0]  note_cache  [CHANNELS];
  logic [CACHE_W-1:0]  instr_cache [CHANNELS];
  logic [CACHE_W-1:0]  vol_cache   [CHANNELS];
  logic [CACHE_W-1:0]  fx_cache    [CHANNELS];
  logic [CACHE_W-1:0]  prm_cache   [CHANNELS];

  logic [CH_IDX_W-1:0] ch;
  logic                ch_ok;
  logic [CACHE_W-1:0]  mask_rd, note_rd, instr_rd, vol_rd, fx_rd, prm_rd;
  logic [CACHE_W-1:0]  note_wr, instr_wr, vol_wr, fx_wr, prm_wr;
  logic [7:0]          evol;
  logic                note_present, instr_present, vol_present, fx_present;
  logic                cell_live, cell_write, cache_clear;
  logic                send_note, send_instr, send_vol, send_fx, new_mask;
  logic [7:0]          mask_pre, mask_fin, chan_byte;

  assign ch    = item.channel[CH_IDX_W-1:0];
  assign ch_ok = {1'b0, item.channel} < (CH_W+1)'(CHANNELS);

  // An entry never written since the last clear reads as nothing cached
  assign mask_rd  = valid[ch] ? mask_cache[ch]  : NOTHING_CACHED;
  assign note_rd  = valid[ch] ? note_cache[ch]  : NOTHING_CACHED;
  assign instr_rd = valid[ch] ? instr_cache[ch] : NOTHING_CACHED;
  assign vol_rd   = valid[ch] ? vol_cache[ch]   : NOTHING_CACHED;
  assign fx_rd    = valid[ch] ? fx_cache[ch]    : NOTHING_CACHED;
  assign prm_rd   = valid[ch] ? prm_cache[ch]   : NOTHING_CACHED;

  assign evol          = cfg.empty_volume_high ? EMPTY_VOL_HIGH : EMPTY_VOL_LOW;
  assign note_present  = item.note != cfg.empty_note;
  assign instr_present = item.instrument != 8'd0;
  assign vol_present   = item.volume != evol;
  assign fx_present    = (item.effect != 8'd0) || (item.effect_param != 8'd0);
  assign cell_live     = ch_ok && (note_present || instr_present || vol_present || fx_present);

  always_comb begin
    mask_pre = 8'd0;
    if (note_present)  mask_pre = mask_pre | FLAG_NOTE | MODE_PLAY;
    if (instr_present) mask_pre = mask_pre | FLAG_INSTR | MODE_DEF_VOL;
    // Note above the empty-note code (such as cut or off): no start, no default volume
    if (item.note > cfg.empty_note) mask_pre = mask_pre & ~(MODE_PLAY | MODE_DEF_VOL);
    if (vol_present)   mask_pre = mask_pre | FLAG_VOLC | MODE_VOL_CMD;
    if (fx_present)    mask_pre = mask_pre | FLAG_EFFC | MODE_FX_CMD;
  end

  assign send_note  = note_present && ({1'b0, item.note} != note_rd);
  assign send_instr = instr_present && ({1'b0, item.instrument} != instr_rd);
  assign send_vol   = vol_present && ({1'b0, item.volume} != vol_rd);
  assign send_fx    = fx_present && !(({1'b0, item.effect} == fx_rd) &&
                                      ({1'b0, item.effect_param} == prm_rd));
  assign mask_fin   = {mask_pre[7:4], send_fx, send_vol, send_instr, send_note};
  assign new_mask   = {1'b0, mask_fin} != mask_rd;
  assign chan_byte  = 8'({3'b000, item.channel} + 8'd1) | (new_mask ? NEW_MASK_BIT : 8'h00);

  assign note_wr  = !send_note ? note_rd :
                    ((item.note == cfg.note_cut_code) || (item.note == cfg.note_off_code)) ?
                    NOTHING_CACHED : {1'b0, item.note};
  assign instr_wr = send_instr ? {1'b0, item.instrument} : instr_rd;
  assign vol_wr   = send_vol ? {1'b0, item.volume} : vol_rd;
  assign fx_wr    = send_fx ? {1'b0, item.effect} : fx_rd;
  assign prm_wr   = send_fx ? {1'b0, item.effect_param} : prm_rd;

  assign cell_write  = fire && (item.op == OP_CELL) && cell_live;
  assign cache_clear = fire && (item.op == OP_RESET);

  always_comb begin
    logic [CNT_W-1:0] pos;
    pos         = '0;
    burst.bytes = '0;
    case (item.op)
      OP_PATTERN: begin
        burst.bytes[0] = item.row_total[7:0] - 8'd1;
        pos = CNT_W'(1);
      end
      OP_END_ROW: begin
        burst.bytes[0] = END_ROW_BYTE;
        pos = CNT_W'(1);
      end
      OP_CELL: begin
        if (cell_live) begin
          burst.bytes[pos] = chan_byte;
          pos = pos + 1'b1;
          if (new_mask) begin
            burst.bytes[pos] = mask_fin;
            pos = pos + 1'b1;
          end
          if (send_note) begin
            burst.bytes[pos] = item.note;
            pos = pos + 1'b1;
          end
          if (send_instr) begin
            burst.bytes[pos] = item.instrument;
            pos = pos + 1'b1;
          end
          if (send_vol) begin
            burst.bytes[pos] = item.volume;
            pos = pos + 1'b1;
          end
          if (send_fx) begin
            burst.bytes[pos] = item.effect;
            pos = pos + 1'b1;
            burst.bytes[pos] = item.effect_param;
            pos = pos + 1'b1;
          end
        end
      end
      default: pos = '0;
    endcase
    burst.count = pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cache_clear) begin
      valid <= '0;
    end else if (cell_write) begin
      valid[ch] <= 1'b1;
    end
  end

  // Write the whole channel row so that a first write fills untouched fields too
  always_ff @(posedge clk) begin
    if (cell_write) begin
      mask_cache[ch]  <= {1'b0, mask_fin};
      note_cache[ch]  <= note_wr;
      instr_cache[ch] <= instr_wr;
      vol_cache[ch]   <= vol_wr;
      fx_cache[ch]    <= fx_wr;
      prm_cache[ch]   <= prm_wr;
    end
  end

endmodule

// ===== src/ttpc_byte_serializer.sv =====
// Result register that holds one burst and hands it out a word at a time.
module ttpc_byte_serializer (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ttpc_pkg::burst_t burst,
  output logic             free,
  output logic             tvalid,
  input  logic             tready,
  output logic [7:0]       tdata,
  output logic             tlast
);
  import ttpc_pkg::*;

  logic                 valid;
  logic [CNT_W-1:0]     idx;
  logic [CNT_W-1:0]     count;
  burst_bytes_t         bytes;

  assign tvalid = valid;
  assign tdata  = bytes[idx];
  assign tlast  = idx == (count - 1'b1);
  assign free   = !valid || (tready && tlast);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (valid && tready && tlast) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= burst.bytes;
      count <= burst.count;
      idx   <= '0;
    end else if (valid && tready && !tlast) begin
      idx <= idx + 1'b1;
    end
  end

endmodule

// ===== src/tracker_pattern_cell_packer_unit.sv =====
// Top level of the tracker pattern cell packer.
//
// Slave channel: one word per pattern item. tuser carries the item kind (cell,
// end of row, pattern start, cache reset); tdata carries the cell fields and
// the row total. Master channel: one word per packed byte, tlast high on the
// final byte that an item produces. Items that produce nothing (empty cells,
// cache resets) leave no trace on the master side.
// Configuration: cfg_we writes cfg_data into register cfg_index; write only
// while the block is idle.
// The first byte of an item passes the input register, then the result
// register, before it is presented on the master side.
// Throughput: the master side moves one byte per cycle while m_axis_tready
// is high; an item has one to seven bytes and holds the result register
// until its last byte leaves, so the rate is set by the byte count of each
// item. The slave side takes a new item every cycle while the result
// register frees in time, and while a burst is still draining the next
// item waits in the input register.
// Reset clears the cache valid bits, so there is no clearing pass; it
// resets the configuration registers, not the data registers.
// A stall on the master side holds the current byte and, once the input
// register is full, drops tready on the slave side.
module tracker_pattern_cell_packer_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // channel, note, instrument, volume, effect, effect_param, row total, pad
  input  logic [ttpc_pkg::DATA_W-1:0]          s_axis_tdata,
  // op
  input  logic [ttpc_pkg::OP_W-1:0]            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // out_byte
  output logic [7:0]                           m_axis_tdata,
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_we,
  input  logic [ttpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ttpc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ttpc_pkg::*;

  cfg_t   cfg;
  item_t  s1_item;
  logic   s1_valid;
  logic   s1_fire;
  logic   ser_free;
  burst_t burst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.empty_volume_high <= 1'b0;
      cfg.empty_note        <= RST_EMPTY_NOTE;
      cfg.note_cut_code     <= RST_NOTE_CUT;
      cfg.note_off_code     <= RST_NOTE_OFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EMPTY_VOL_HIGH: cfg.empty_volume_high <= cfg_data[0];
        REG_EMPTY_NOTE:     cfg.empty_note        <= cfg_data;
        REG_NOTE_CUT:       cfg.note_cut_code     <= cfg_data;
        REG_NOTE_OFF:       cfg.note_off_code     <= cfg_data;
        default:            cfg.empty_note        <= cfg.empty_note;
      endcase
    end
  end

  // An item with no bytes passes through without waiting for the result register
  assign s1_fire       = s1_valid && (ser_free || (burst.count == '0));
  assign s_axis_tready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_item.op           <= s_axis_tuser;
      s1_item.channel      <= s_axis_tdata[4:0];
      s1_item.note         <= s_axis_tdata[12:5];
      s1_item.instrument   <= s_axis_tdata[20:13];
      s1_item.volume       <= s_axis_tdata[28:21];
      s1_item.effect       <= s_axis_tdata[36:29];
      s1_item.effect_param <= s_axis_tdata[44:37];
      s1_item.row_total    <= s_axis_tdata[53:45];
    end
  end

  ttpc_cell_encoder u_encoder (
    .clk   (clk),
    .rst   (rst),
    .item  (s1_item),
    .cfg   (cfg),
    .fire  (s1_fire),
    .burst (burst)
  );

  ttpc_byte_serializer u_serializer (
    .clk    (clk),
    .rst    (rst),
    .load   (s1_fire && (burst.count != '0)),
    .burst  (burst),
    .free   (ser_free),
    .tvalid (m_axis_tvalid),
    .tready (m_axis_tready),
    .tdata  (m_axis_tdata),
    .tlast  (m_axis_tlast)
  );

endmodule

// ===== src/ttpc_checker.sv =====
// Port-level checks of the tracker pattern cell packer, bound to the top level.
module ttpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // A stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output word changed");

  // A burst leaves without gaps until its last word
  a_burst_gapless: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside an output burst");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid straight after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> s_axis_tready)
    else $error("input not ready straight after reset");

  // An idle input side is never blocked
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tvalid && !m_axis_tvalid |=> s_axis_tready)
    else $error("input not ready while the block is idle");

endmodule

bind tracker_pattern_cell_packer_unit ttpc_checker u_ttpc_checker (.*);

// ===== tb/tracker_pattern_cell_packer_unit_tb.sv =====
// Testbench for the tracker pattern cell packer: predicted byte stream checked word by word.
`timescale 1ns / 1ps

module tracker_pattern_cell_packer_unit_tb;
  import ttpc_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } stream_byte_t;

  class packed_stream_model;
    logic               empty_volume_high;
    logic [7:0]         empty_note;
    logic [7:0]         note_cut_code;
    logic [7:0]         note_off_code;
    logic [CACHE_W-1:0] mask_cache[CHANNELS];
    logic [CACHE_W-1:0] note_cache[CHANNELS];
    logic [CACHE_W-1:0] instrument_cache[CHANNELS];
    logic [CACHE_W-1:0] volume_cache[CHANNELS];
    logic [CACHE_W-1:0] effect_cache[CHANNELS];
    logic [CACHE_W-1:0] param_cache[CHANNELS];
    stream_byte_t       expected_bytes[$];
    int                 errors;

    function new();
      errors            = 0;
      empty_volume_high = 1'b0;
      empty_note        = RST_EMPTY_NOTE;
      note_cut_code     = RST_NOTE_CUT;
      note_off_code     = RST_NOTE_OFF;
      clear_caches();
    endfunction

    function void clear_caches();
      for (int c = 0; c < CHANNELS; c++) begin
        mask_cache[c]       = NOTHING_CACHED;
        note_cache[c]       = NOTHING_CACHED;
        instrument_cache[c] = NOTHING_CACHED;
        volume_cache[c]     = NOTHING_CACHED;
        effect_cache[c]     = NOTHING_CACHED;
        param_cache[c]      = NOTHING_CACHED;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_EMPTY_VOL_HIGH: empty_volume_high = data[0];
        REG_EMPTY_NOTE:     empty_note        = data;
        REG_NOTE_CUT:       note_cut_code     = data;
        REG_NOTE_OFF:       note_off_code     = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] empty_volume();
      return empty_volume_high ? EMPTY_VOL_HIGH : EMPTY_VOL_LOW;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    // Work out the bytes that one accepted item produces and update the caches.
    function void note_item(item_t it);
      logic [7:0]   evol;
      logic [7:0]   mask;
      logic [7:0]   chan_byte;
      logic [8:0]   header;
      logic [7:0]   out_bytes[$];
      stream_byte_t entry;
      int           c;
      evol = empty_volume();
      mask = 8'h00;
      c    = it.channel;
      case (it.op)
        OP_RESET: clear_caches();
        OP_PATTERN: begin
          header = it.row_total - 9'd1;
          out_bytes.push_back(header[7:0]);
        end
        OP_END_ROW: out_bytes.push_back(END_ROW_BYTE);
        default: begin
          if (c < CHANNELS && !(it.note == empty_note && it.instrument == 8'h00 &&
              it.volume == evol && it.effect == 8'h00 && it.effect_param == 8'h00)) begin
            if (it.note != empty_note) mask |= FLAG_NOTE | MODE_PLAY;
            if (it.instrument != 8'h00) mask |= FLAG_INSTR | MODE_DEF_VOL;
            if (it.note > empty_note) mask &= ~(MODE_PLAY | MODE_DEF_VOL);
            if (it.volume != evol) mask |= FLAG_VOLC | MODE_VOL_CMD;
            if (it.effect != 8'h00 || it.effect_param != 8'h00) mask |= FLAG_EFFC | MODE_FX_CMD;

            if ((mask & FLAG_NOTE) != 0) begin
              if ({1'b0, it.note} == note_cache[c]) mask &= ~FLAG_NOTE;
              else if (it.note == note_cut_code || it.note == note_off_code)
                note_cache[c] = NOTHING_CACHED;
              else note_cache[c] = {1'b0, it.note};
            end
            if ((mask & FLAG_INSTR) != 0) begin
              if ({1'b0, it.instrument} == instrument_cache[c]) mask &= ~FLAG_INSTR;
              else instrument_cache[c] = {1'b0, it.instrument};
            end
            if ((mask & FLAG_VOLC) != 0) begin
              if ({1'b0, it.volume} == volume_cache[c]) mask &= ~FLAG_VOLC;
              else volume_cache[c] = {1'b0, it.volume};
            end
            if ((mask & FLAG_EFFC) != 0) begin
              if ({1'b0, it.effect} == effect_cache[c] &&
                  {1'b0, it.effect_param} == param_cache[c]) begin
                mask &= ~FLAG_EFFC;
              end else begin
                effect_cache[c] = {1'b0, it.effect};
                param_cache[c]  = {1'b0, it.effect_param};
              end
            end

            chan_byte = {3'b000, it.channel} + 8'd1;
            if ({1'b0, mask} != mask_cache[c]) begin
              chan_byte |= NEW_MASK_BIT;
              mask_cache[c] = {1'b0, mask};
            end
            out_bytes.push_back(chan_byte);
            if ((chan_byte & NEW_MASK_BIT) != 0) out_bytes.push_back(mask);
            if ((mask & FLAG_NOTE) != 0) out_bytes.push_back(it.note);
            if ((mask & FLAG_INSTR) != 0) out_bytes.push_back(it.instrument);
            if ((mask & FLAG_VOLC) != 0) out_bytes.push_back(it.volume);
            if ((mask & FLAG_EFFC) != 0) begin
              out_bytes.push_back(it.effect);
              out_bytes.push_back(it.effect_param);
            end
          end
        end
      endcase
      foreach (out_bytes[i]) begin
        entry.value = out_bytes[i];
        entry.last  = (i == out_bytes.size() - 1);
        expected_bytes.push_back(entry);
      end
    endfunction

    function void check_byte(logic [7:0] value, logic last);
      stream_byte_t entry;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected word %02h last %0b, nothing expected", $time, value, last);
        errors++;
      end else begin
        entry = expected_bytes.pop_front();
        if (entry.value !== value) begin
          $display("%0t: byte mismatch: expected %02h, actual %02h", $time, entry.value, value);
          errors++;
        end
        if (entry.last !== last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b", $time, entry.last, last);
          errors++;
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [DATA_W-1:0]     s_axis_tdata;
  logic [OP_W-1:0]       s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [7:0]            m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  packed_stream_model stream;
  int                 items_sent  = 0;
  int                 hold_cycles = 0;
  bit                 no_gaps     = 1'b0;
  bit                 held_off    = 1'b0;
  bit                 paused      = 1'b0;

  tracker_pattern_cell_packer_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic item_t make_item(logic [OP_W-1:0] op, int ch, int note, int ins,
                                      int vol, int fx, int prm, int rows);
    item_t it;
    it.op           = op;
    it.channel      = 5'(ch);
    it.note         = 8'(note);
    it.instrument   = 8'(ins);
    it.volume       = 8'(vol);
    it.effect       = 8'(fx);
    it.effect_param = 8'(prm);
    it.row_total    = 9'(rows);
    return it;
  endfunction

  function automatic item_t noise_item();
    return make_item(OP_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
  endfunction

  // Cells drawn from small pools so that the caches hit often.
  function automatic item_t random_cell();
    item_t it;
    int    r;
    it = noise_item();
    it.op = OP_CELL;
    it.channel = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 3)) : 5'($urandom);
    r = $urandom_range(0, 9);
    if (r < 3) it.note = stream.empty_note;
    else if (r == 3) it.note = stream.note_cut_code;
    else if (r == 4) it.note = stream.note_off_code;
    else if (r == 6 && stream.empty_note != 8'hFF)
      it.note = 8'($urandom_range(int'(stream.empty_note) + 1, 255));
    else if (r > 6) it.note = 8'(48 + 4 * $urandom_range(0, 3));
    r = $urandom_range(0, 9);
    if (r < 4) it.instrument = 8'h00;
    else if (r < 8) it.instrument = 8'($urandom_range(1, 2));
    r = $urandom_range(0, 9);
    if (r < 4) it.volume = stream.empty_volume();
    else if (r < 7) it.volume = 8'(32 << $urandom_range(0, 1));
    r = $urandom_range(0, 9);
    if (r < 4) begin
      it.effect       = 8'h00;
      it.effect_param = 8'h00;
    end else if (r < 7) begin
      it.effect       = 8'($urandom_range(1, 2));
      it.effect_param = 8'h10;
    end
    return it;
  endfunction

  task automatic send_item(item_t it);
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = it.op;
    s_axis_tdata  = {2'b00, it.row_total, it.effect_param, it.effect, it.volume,
                     it.instrument, it.note, it.channel};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    stream.note_item(it);
    items_sent++;
  endtask

  task automatic sender_gap(int n);
    if (n > 0) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_paced(item_t it);
    send_item(it);
    if (!no_gaps) sender_gap(random_gap());
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (stream.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    stream.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Wait out any item that produces nothing before touching the registers.
  task automatic configure(logic evh, logic [7:0] en, logic [7:0] cut, logic [7:0] off);
    drain();
    repeat (12) @(posedge clk);
    write_reg(REG_EMPTY_VOL_HIGH, {7'd0, evh});
    write_reg(REG_EMPTY_NOTE, en);
    write_reg(REG_NOTE_CUT, cut);
    write_reg(REG_NOTE_OFF, off);
  endtask

  task automatic random_sequence();
    int r;
    no_gaps = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 99);
    if (r < 15) begin
      repeat ($urandom_range(1, 4)) send_paced(noise_item());
    end else begin
      if ($urandom_range(0, 4) == 0) send_paced(make_item(OP_RESET, 0, 0, 0, 0, 0, 0, 0));
      send_paced(make_item(OP_PATTERN, 0, 0, 0, 0, 0, 0,
                           ($urandom_range(0, 3) == 0) ? $urandom_range(1, 256) : 64));
      repeat ($urandom_range(1, 5)) begin
        repeat ($urandom_range(0, 4)) send_paced(random_cell());
        // drop the end of row now and then to break the sequence
        if ($urandom_range(0, 9) != 0) send_paced(make_item(OP_END_ROW, 0, 0, 0, 0, 0, 0, 0));
      end
    end
    no_gaps = 1'b0;
  endtask

  // Receiver: random ready pattern, plus a long hold-off on request.
  initial begin
    int run;
    int gap;
    m_axis_tready = 1'b0;
    forever begin
      if (hold_cycles > 0) begin
        run = hold_cycles;
        hold_cycles = 0;
        @(negedge clk);
        m_axis_tready = 1'b0;
        repeat (run - 1) @(negedge clk);
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      @(negedge clk);
      m_axis_tready = 1'b1;
      repeat (run - 1) @(negedge clk);
      gap = random_gap();
      if (gap > 0) begin
        @(negedge clk);
        m_axis_tready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) stream.check_byte(m_axis_tdata, m_axis_tlast);
    end
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [7:0] en;
    stream        = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_CELL;
    cfg_we        = 1'b0;
    cfg_index     = REG_EMPTY_VOL_HIGH;
    cfg_data      = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    configure(1'b0, RST_EMPTY_NOTE, RST_NOTE_CUT, RST_NOTE_OFF);
    send_paced(make_item(OP_PATTERN, 0, 0, 0, 0, 0, 0, 1));
    send_paced(make_item(OP_PATTERN, 0, 0, 0, 0, 0, 0, 0));       // header wraps to 0xFF
    send_paced(make_item(OP_PATTERN, 0, 0, 0, 0, 0, 0, 256));
    send_paced(make_item(OP_PATTERN, 0, 0, 0, 0, 0, 0, 511));
    send_paced(make_item(OP_END_ROW, 0, 0, 0, 0, 0, 0, 0));
    send_paced(make_item(OP_CELL, 0, 250, 0, 0, 0, 0, 0));        // empty cell
    send_paced(make_item(OP_CELL, 0, 60, 1, 64, 1, 2, 0));
    send_paced(make_item(OP_CELL, 0, 60, 1, 64, 1, 2, 0));        // all cached
    send_paced(make_item(OP_CELL, 31, 255, 255, 255, 255, 255, 511));
    send_paced(make_item(OP_CELL, 31, 255, 255, 255, 255, 255, 0)); // off never cached
    send_paced(make_item(OP_CELL, 31, 254, 0, 0, 0, 0, 0));       // note cut
    send_paced(make_item(OP_CELL, 5, 251, 3, 0, 0, 0, 0));        // above empty note
    send_paced(make_item(OP_CELL, 5, 251, 3, 0, 0, 0, 0));
    send_paced(make_item(OP_CELL, 5, 0, 0, 0, 0, 1, 0));
    send_paced(make_item(OP_CELL, 5, 0, 0, 0, 7, 0, 0));
    send_paced(make_item(OP_PATTERN, 0, 0, 0, 0, 0, 0, 32));      // caches kept
    send_paced(make_item(OP_CELL, 5, 0, 0, 0, 7, 0, 0));
    send_paced(make_item(OP_RESET, 0, 0, 0, 0, 0, 0, 0));
    send_paced(make_item(OP_CELL, 0, 60, 1, 64, 1, 2, 0));
    send_paced(make_item(OP_CELL, 1, 250, 9, 0, 0, 0, 0));
    send_paced(make_item(OP_CELL, 1, 250, 0, 128, 0, 0, 0));
    send_paced(make_item(OP_END_ROW, 0, 0, 0, 0, 0, 0, 0));

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: configure(1'b0, RST_EMPTY_NOTE, RST_NOTE_CUT, RST_NOTE_OFF);
        1: configure(1'b1, 8'h00, 8'h00, 8'hFF);
        2: configure(1'b0, 8'hFF, 8'hFF, 8'h00);
        3: configure(1'b1, 8'd128, 8'd200, 8'd100);
        4: begin
          en = 8'($urandom_range(200, 254));
          configure(1'($urandom), en, 8'($urandom_range(int'(en), 255)),
                    8'($urandom_range(int'(en), 255)));
        end
        default: configure(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      while (items_sent < 22 + (phase + 1) * 73) begin
        random_sequence();
        // hold the receiver off so the block backs up into its input
        if (phase == 1 && !held_off && items_sent > 22 + 73 + 20) begin
          hold_cycles = 300;
          held_off    = 1'b1;
        end
        if (phase == 2 && !paused && items_sent > 22 + 2 * 73 + 30) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    repeat (12) @(posedge clk);
    if (stream.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
